### rtl/bmf3_pkg.sv
`default_nettype none
package bmf3_pkg;

	localparam int CFG_W         = 11;
	localparam int ROW_W         = 10;
	localparam int OUT_COORD_W   = 10;
	localparam int PIX_W         = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int HEIGHT_LIMIT  = 1024;
	localparam int MIN_DIM       = 3;
	localparam int WIN_SIZE      = 9;
	localparam int MAJORITY      = 5;
	localparam int TDATA_OUT_W   = 32;

	localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
	localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic                   emit;
		logic                   interior;
		logic                   last;
		logic [OUT_COORD_W-1:0] row;
		logic [OUT_COORD_W-1:0] col;
	} pos_t;

endpackage
`default_nettype wire

### rtl/binary_majority_filter_3x3_unit.sv
// 3x3 binary majority filter on a raster pixel stream.
// s_* channel: one pixel per transaction, s_tuser marks the first pixel of
// a frame. m_* channel: one filtered centre pixel with its row and column;
// m_tlast flags the centre at (height-2, width-2). Pixels in row 0 or
// column 0 of the image produce no transaction; border centres give 0.
// cfg_we/cfg_index/cfg_data write frame_width (0) and frame_height (1); the user
// must write only while the block is idle; the block does not enforce this.
// Throughput: one pixel per clock while m_tready is high; the line store has a
// read and a write port, read when a pixel is taken and written when it leaves
// the middle stage. Pipeline: a taken pixel is held in the middle stage beside
// the line store read register, then in the output register that drives m_*.
// Reset: size registers go to 640 x 480, position and window clear; the
// line stores are not cleared and hold stale rows until written.
// Stall: m_* holds its transaction, one more pixel is held in the middle
// stage, then s_tready drops until m_tready returns.
`default_nettype none
module binary_majority_filter_3x3_unit #(
	parameter int MAX_WIDTH = bmf3_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [bmf3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bmf3_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [7:0]                           s_tdata,  // pixel_value
	input  wire logic                                 s_tuser,  // frame_start
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// filtered_pixel, out_row, out_col, zero fill
	output logic      [bmf3_pkg::TDATA_OUT_W-1:0]     m_tdata,
	output logic                                      m_tlast   // frame_last
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic                       accept;
	logic                       s1_adv;
	bmf3_pkg::pos_t             pos;
	logic [COL_W-1:0]           addr;
	logic [1:0]                 rd_data;
	logic [bmf3_pkg::PIX_W-1:0] filtered;

	logic                       valid_s1;
	logic                       pix_s1;
	bmf3_pkg::pos_t             pos_s1;
	logic [COL_W-1:0]           addr_s1;

	logic                       valid_s2;
	logic [bmf3_pkg::PIX_W-1:0] pixel_s2;
	logic [bmf3_pkg::OUT_COORD_W-1:0] row_s2, col_s2;
	logic                       last_s2;

	assign s1_adv   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign accept   = s_tvalid && s_tready;

	bmf3_position #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_position (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.advance     (accept),
		.frame_start (s_tuser),
		.pos         (pos),
		.addr        (addr)
	);

	bmf3_line_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (addr),
		.rd_data (rd_data),
		.wr_en   (s1_adv),
		.wr_addr (addr_s1),
		.wr_data ({rd_data[0], pix_s1})
	);

	bmf3_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (s1_adv),
		.up       (rd_data[1]),
		.lo       (rd_data[0]),
		.pix      (pix_s1),
		.interior (pos_s1.interior),
		.filtered (filtered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= (s_tdata != '0);
			pos_s1  <= pos;
			addr_s1 <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= pos_s1.emit;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_s2 <= filtered;
			row_s2   <= pos_s1.row;
			col_s2   <= pos_s1.col;
			last_s2  <= pos_s1.last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {{(bmf3_pkg::TDATA_OUT_W - bmf3_pkg::PIX_W
		- 2 * bmf3_pkg::OUT_COORD_W){1'b0}}, col_s2, row_s2, pixel_s2};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("input taken while middle stage is stalled");

	a_binary_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd255))
		else $error("filtered pixel not black or white");

	a_border_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[17:8] == 10'd0 || m_tdata[27:18] == 10'd0)
		|-> m_tdata[7:0] == 8'd0)
		else $error("border centre not black");

	a_no_skip_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && pos_s1.emit |=> m_tvalid)
		else $error("emitted centre lost");

endmodule
`default_nettype wire

### rtl/bmf3_line_store.sv
`default_nettype none
module bmf3_line_store #(
	parameter int DEPTH  = bmf3_pkg::DEF_MAX_WIDTH,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [1:0]        rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [1:0]        wr_data
);

	// bit 1: row r-2, bit 0: row r-1
	logic [1:0] mem [DEPTH];
	logic [1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-first so a repeated column sees the value just written
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

### rtl/bmf3_position.sv
`default_nettype none
module bmf3_position #(
	parameter int MAX_WIDTH = bmf3_pkg::DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [bmf3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bmf3_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                 advance,
	input  wire logic                                 frame_start,
	output bmf3_pkg::pos_t                            pos,
	output logic      [COL_W-1:0]                     addr
);

	localparam int CMP_W = (COL_W + 1 > bmf3_pkg::CFG_W) ? COL_W + 1 : bmf3_pkg::CFG_W;
	localparam int RW    = bmf3_pkg::ROW_W + 1;

	logic [bmf3_pkg::CFG_W-1:0] width_q, height_q;
	logic [COL_W-1:0]           col_q;
	logic [bmf3_pkg::ROW_W-1:0] row_q;

	logic [CMP_W-1:0] w, c0, c1, cn, c1m;
	logic [RW-1:0]    h, r0, r1, r2, rn, r2m;
	logic [CMP_W-1:0] w_cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmf3_pkg::RST_FRAME_WIDTH;
			height_q <= bmf3_pkg::RST_FRAME_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmf3_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
				bmf3_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_cfg = CMP_W'(width_q);
		if (w_cfg < CMP_W'(bmf3_pkg::MIN_DIM)) begin
			w = CMP_W'(bmf3_pkg::MIN_DIM);
		end else if (w_cfg > CMP_W'(MAX_WIDTH)) begin
			w = CMP_W'(MAX_WIDTH);
		end else begin
			w = w_cfg;
		end
		if (height_q < RW'(bmf3_pkg::MIN_DIM)) begin
			h = RW'(bmf3_pkg::MIN_DIM);
		end else if (height_q > RW'(bmf3_pkg::HEIGHT_LIMIT)) begin
			h = RW'(bmf3_pkg::HEIGHT_LIMIT);
		end else begin
			h = height_q;
		end

		c0 = frame_start ? '0 : CMP_W'(col_q);
		r0 = frame_start ? '0 : RW'(row_q);
		if (c0 >= w) begin
			c1 = '0;
			r1 = r0 + RW'(1);
		end else begin
			c1 = c0;
			r1 = r0;
		end
		r2 = (r1 >= h) ? '0 : r1;

		cn = c1 + CMP_W'(1);
		rn = r2;
		if (cn >= w) begin
			cn = '0;
			rn = r2 + RW'(1);
			if (rn >= h) begin
				rn = '0;
			end
		end

		c1m = c1 - CMP_W'(1);
		r2m = r2 - RW'(1);
		pos.emit     = (r2 >= RW'(1)) && (c1 >= CMP_W'(1));
		pos.interior = (r2 >= RW'(2)) && (c1 >= CMP_W'(2));
		pos.last     = (r2 == h - RW'(1)) && (c1 == w - CMP_W'(1));
		pos.row      = r2m[bmf3_pkg::OUT_COORD_W-1:0];
		pos.col      = c1m[bmf3_pkg::OUT_COORD_W-1:0];
		addr         = c1[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= cn[COL_W-1:0];
			row_q <= rn[bmf3_pkg::ROW_W-1:0];
		end
	end

endmodule
`default_nettype wire

### rtl/bmf3_window.sv
`default_nettype none
module bmf3_window (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic                          up,
	input  wire logic                          lo,
	input  wire logic                          pix,
	input  wire logic                          interior,
	output logic      [bmf3_pkg::PIX_W-1:0]    filtered
);

	logic [bmf3_pkg::WIN_SIZE-1:0] window_q;
	logic [bmf3_pkg::WIN_SIZE-1:0] window_next;
	logic [3:0]                    whites;

	assign window_next = {window_q[bmf3_pkg::WIN_SIZE-4:0], up, lo, pix};
	assign whites      = 4'($countones(window_next));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (advance) begin
			window_q <= window_next;
		end
	end

	// fewer than five black means at least five white
	assign filtered = (interior && whites >= 4'(bmf3_pkg::MAJORITY)) ?
		bmf3_pkg::PIX_WHITE : bmf3_pkg::PIX_BLACK;

endmodule
`default_nettype wire
